>>> rtl/core/gsp_pkg.sv
`default_nettype none
package gsp_pkg;

  // Field and datapath widths
  localparam int COORD_W  = 20;
  localparam int POS_W    = 21;
  localparam int SPAN_W   = 22;
  localparam int MAG_W    = 21;
  localparam int PITCH_W  = 16;
  localparam int LINK_W   = 12;
  localparam int CHOICE_W = 18;

  // Numerator width of the index divider in the back part
  localparam int IDX_NUM_W = 35;

  // Cycles from an accepted word to its result strobe
  localparam int PIPE_LAT = MAG_W + IDX_NUM_W + 5;

  // Word handed from the front part to the back part through the queue
  typedef struct packed {
    logic                       opcode;
    logic                       horiz;
    logic [LINK_W-1:0]          link_number;
    logic [LINK_W-1:0]          link_total;
    logic [CHOICE_W-1:0]        stored_choice;
    logic signed [SPAN_W-1:0]   first;
    logic signed [SPAN_W-1:0]   last;
    logic signed [SPAN_W-1:0]   edge_pos;
    logic signed [POS_W-1:0]    cx;
    logic signed [POS_W-1:0]    cy;
  } gsp_mid_t;

endpackage
`default_nettype wire

>>> rtl/core/gsp_div.sv
`default_nettype none
module gsp_div #(
  parameter int LN = 1,
  parameter int NW = 8,
  parameter int DW = 8,
  parameter int PW = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [LN-1:0][NW-1:0]  in_num,
  input  logic [DW-1:0]          in_den,
  input  logic [PW-1:0]          in_pay,
  output logic                   out_vld,
  output logic [LN-1:0][NW-1:0]  out_quo,
  output logic [PW-1:0]          out_pay
);

  // One quotient bit per stage, all lanes share the divisor
  logic                  vld_r   [NW];
  logic [LN-1:0][NW-1:0] wd_r    [NW];
  logic [LN-1:0][DW-1:0] rem_r   [NW];
  logic [DW-1:0]         den_r   [NW];
  logic [PW-1:0]         pay_r   [NW];

  logic                  vld_p   [NW];
  logic [LN-1:0][NW-1:0] wd_p    [NW];
  logic [LN-1:0][DW-1:0] rem_p   [NW];
  logic [DW-1:0]         den_p   [NW];
  logic [PW-1:0]         pay_p   [NW];

  logic [LN-1:0][NW-1:0] wd_nxt  [NW];
  logic [LN-1:0][DW-1:0] rem_nxt [NW];

  // Feed each stage from the one before it
  always_comb begin
    vld_p[0] = in_vld;
    wd_p[0]  = in_num;
    rem_p[0] = '0;
    den_p[0] = in_den;
    pay_p[0] = in_pay;
    for (int k = 1; k < NW; k++) begin
      vld_p[k] = vld_r[k-1];
      wd_p[k]  = wd_r[k-1];
      rem_p[k] = rem_r[k-1];
      den_p[k] = den_r[k-1];
      pay_p[k] = pay_r[k-1];
    end
  end

  // Shift in the next numerator bit, subtract when it fits
  always_comb begin
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        qbit;
    trial = '0;
    diff  = '0;
    qbit  = 1'b0;
    for (int k = 0; k < NW; k++) begin
      for (int l = 0; l < LN; l++) begin
        trial = {rem_p[k][l], wd_p[k][l][NW-1]};
        diff  = trial - {1'b0, den_p[k]};
        qbit  = (trial >= {1'b0, den_p[k]});
        rem_nxt[k][l] = qbit ? diff[DW-1:0] : trial[DW-1:0];
        wd_nxt[k][l]  = {wd_p[k][l][NW-2:0], qbit};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NW; k++) vld_r[k] <= 1'b0;
    end else begin
      for (int k = 0; k < NW; k++) vld_r[k] <= vld_p[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NW; k++) begin
      wd_r[k]  <= wd_nxt[k];
      rem_r[k] <= rem_nxt[k];
      den_r[k] <= den_p[k];
      pay_r[k] <= pay_p[k];
    end
  end

  assign out_vld = vld_r[NW-1];
  assign out_quo = wd_r[NW-1];
  assign out_pay = pay_r[NW-1];

endmodule
`default_nettype wire

>>> rtl/core/gsp_front.sv
`default_nettype none
module gsp_front import gsp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_vld,
  input  logic                      in_opcode,
  input  logic signed [COORD_W-1:0] in_left_coord,
  input  logic signed [COORD_W-1:0] in_top_coord,
  input  logic [CHOICE_W-1:0]       in_box_width,
  input  logic [CHOICE_W-1:0]       in_box_height,
  input  logic [1:0]                in_side,
  input  logic [LINK_W-1:0]         in_link_number,
  input  logic [LINK_W-1:0]         in_link_total,
  input  logic [CHOICE_W-1:0]       in_stored_choice,
  input  logic [PITCH_W-1:0]        pitch,
  output logic                      out_vld,
  output gsp_mid_t                  out_item
);

  localparam logic [1:0] SIDE_TOP    = 2'd0;
  localparam logic [1:0] SIDE_BOTTOM = 2'd1;
  localparam logic [1:0] SIDE_LEFT   = 2'd2;
  localparam logic [1:0] SIDE_RIGHT  = 2'd3;

  typedef struct packed {
    logic [2:0]                neg;
    logic                      opcode;
    logic                      horiz;
    logic [LINK_W-1:0]         n;
    logic [LINK_W-1:0]         t;
    logic [CHOICE_W-1:0]       stored;
    logic signed [POS_W-1:0]   cx;
    logic signed [POS_W-1:0]   cy;
  } gsp_fpay_t;

  localparam int FPW = $bits(gsp_fpay_t);

  // Turn floor or ceiling division of a signed value into an unsigned one
  // on a biased magnitude; the top bit says to negate the quotient
  function automatic logic [MAG_W:0] prep(input logic signed [SPAN_W-1:0] a,
                                          input logic [PITCH_W-1:0] g,
                                          input logic is_ceil);
    logic signed [SPAN_W-1:0] v;
    logic [SPAN_W-1:0]        m;
    logic                     neg;
    v = is_ceil ? -a : a;
    if (v[SPAN_W-1]) begin
      m   = SPAN_W'(-v) + SPAN_W'(g) - SPAN_W'(1);
      neg = ~is_ceil;
    end else begin
      m   = v;
      neg = is_ceil;
    end
    return {neg, m[MAG_W-1:0]};
  endfunction

  logic signed [SPAN_W-1:0] xe, ye, xr, yb, lo, hi, edge_a;
  logic                     edge_c, horiz;
  logic [MAG_W:0]           p_first, p_last, p_edge;
  logic [2:0][MAG_W-1:0]    div_num;
  gsp_fpay_t                pay_in, pay_out;
  logic [FPW-1:0]           pay_out_w;
  logic [2:0][MAG_W-1:0]    div_quo;
  logic signed [SPAN_W-1:0] q [3];

  // Classify the side and form the three dividends
  always_comb begin
    xe    = SPAN_W'(in_left_coord);
    ye    = SPAN_W'(in_top_coord);
    xr    = xe + SPAN_W'(in_box_width);
    yb    = ye + SPAN_W'(in_box_height);
    horiz = ~in_side[1];
    lo    = horiz ? xe : ye;
    hi    = horiz ? xr : yb;
    case (in_side)
      SIDE_TOP: begin
        edge_a = ye;
        edge_c = 1'b0;
      end
      SIDE_BOTTOM: begin
        edge_a = yb;
        edge_c = 1'b1;
      end
      SIDE_LEFT: begin
        edge_a = xe;
        edge_c = 1'b0;
      end
      SIDE_RIGHT: begin
        edge_a = xr;
        edge_c = 1'b1;
      end
      default: begin
        edge_a = xe;
        edge_c = 1'b0;
      end
    endcase
    p_first = prep(lo, pitch, 1'b1);
    p_last  = prep(hi, pitch, 1'b0);
    p_edge  = prep(edge_a, pitch, edge_c);
    div_num = {p_edge[MAG_W-1:0], p_last[MAG_W-1:0], p_first[MAG_W-1:0]};
    pay_in.neg    = {p_edge[MAG_W], p_last[MAG_W], p_first[MAG_W]};
    pay_in.opcode = in_opcode;
    pay_in.horiz  = horiz;
    pay_in.n      = in_link_number;
    pay_in.t      = in_link_total;
    pay_in.stored = in_stored_choice;
    pay_in.cx     = POS_W'(in_left_coord) + POS_W'(in_box_width[CHOICE_W-1:1]);
    pay_in.cy     = POS_W'(in_top_coord) + POS_W'(in_box_height[CHOICE_W-1:1]);
  end

  gsp_div #(
    .LN (3),
    .NW (MAG_W),
    .DW (PITCH_W),
    .PW (FPW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (in_vld),
    .in_num  (div_num),
    .in_den  (pitch),
    .in_pay  (pay_in),
    .out_vld (out_vld),
    .out_quo (div_quo),
    .out_pay (pay_out_w)
  );

  // Apply the sign and hand the word to the queue
  always_comb begin
    pay_out = gsp_fpay_t'(pay_out_w);
    for (int l = 0; l < 3; l++) begin
      q[l] = pay_out.neg[l] ? -SPAN_W'(div_quo[l]) : SPAN_W'(div_quo[l]);
    end
    out_item.opcode        = pay_out.opcode;
    out_item.horiz         = pay_out.horiz;
    out_item.link_number   = pay_out.n;
    out_item.link_total    = pay_out.t;
    out_item.stored_choice = pay_out.stored;
    out_item.first         = q[0];
    out_item.last          = q[1];
    out_item.edge_pos      = q[2];
    out_item.cx            = pay_out.cx;
    out_item.cy            = pay_out.cy;
  end

endmodule
`default_nettype wire

>>> rtl/core/gsp_queue.sv
`default_nettype none
module gsp_queue import gsp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  gsp_mid_t push_item,
  input  logic     pop,
  output logic     full,
  output logic     out_vld,
  output gsp_mid_t out_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gsp_mid_t           mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r, wr_ptr_nxt, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign do_push = push && (count_r != CNT_W'(DEPTH));
  assign do_pop  = pop && (count_r != '0);

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
    if (!do_push && do_pop) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_item;
  end

  assign full     = (count_r == CNT_W'(DEPTH));
  assign out_vld  = (count_r != '0);
  assign out_item = mem[rd_ptr_r];

endmodule
`default_nettype wire

>>> rtl/core/gsp_back.sv
`default_nettype none
module gsp_back import gsp_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  gsp_mid_t                in_item,
  input  logic [PITCH_W-1:0]      pitch,
  output logic                    out_strobe,
  output logic signed [POS_W-1:0] out_snap_x,
  output logic signed [POS_W-1:0] out_snap_y,
  output logic [CHOICE_W-1:0]     out_chosen_index,
  output logic                    out_at_center
);

  localparam logic [1:0] SEL_STORED = 2'd0;
  localparam logic [1:0] SEL_DIRECT = 2'd1;
  localparam logic [1:0] SEL_SHARE  = 2'd2;
  localparam logic [1:0] SEL_SPREAD = 2'd3;

  localparam int PROD_W = IDX_NUM_W - 1;
  localparam int DEN_W  = LINK_W + 2;

  typedef struct packed {
    logic                 empty;
    logic [1:0]           mode;
    logic [POS_W-1:0]     cm1;
    logic [CHOICE_W-1:0]  val;
    logic [POS_W-1:0]     first;
    logic [POS_W-1:0]     edge_pos;
    logic [POS_W-1:0]     cx;
    logic [POS_W-1:0]     cy;
    logic                 horiz;
  } gsp_bpay_t;

  localparam int BPW = $bits(gsp_bpay_t);

  // Count the points and pick the selection rule
  logic signed [POS_W+1:0] cnt;
  logic [POS_W-1:0]        c0;
  logic [1:0]              mode0;
  gsp_bpay_t               pay0;

  always_comb begin
    cnt = (POS_W+2)'(in_item.last) - (POS_W+2)'(in_item.first) + (POS_W+2)'(1);
    c0  = cnt[POS_W-1:0];
    if (in_item.opcode) begin
      mode0 = SEL_STORED;
    end else if (in_item.link_number >= in_item.link_total) begin
      mode0 = SEL_DIRECT;
    end else if (POS_W'(in_item.link_total) >= c0) begin
      mode0 = SEL_SHARE;
    end else begin
      mode0 = SEL_SPREAD;
    end
    pay0.empty    = cnt[POS_W+1] || (cnt == '0);
    pay0.mode     = mode0;
    pay0.cm1      = c0 - POS_W'(1);
    pay0.val      = in_item.opcode ? in_item.stored_choice
                                   : CHOICE_W'(in_item.link_number);
    pay0.first    = in_item.first[POS_W-1:0];
    pay0.edge_pos = in_item.edge_pos[POS_W-1:0];
    pay0.cx       = in_item.cx;
    pay0.cy       = in_item.cy;
    pay0.horiz    = in_item.horiz;
  end

  logic              b0_vld_r;
  gsp_bpay_t         b0_pay_r;
  logic [POS_W-1:0]  b0_c_r;
  logic [LINK_W-1:0] b0_n_r, b0_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b0_vld_r <= 1'b0;
    else        b0_vld_r <= in_vld;
  end

  always_ff @(posedge clk) begin
    b0_pay_r <= pay0;
    b0_c_r   <= c0;
    b0_n_r   <= in_item.link_number;
    b0_t_r   <= in_item.link_total;
  end

  // Multiply for the index numerator
  logic              share0;
  logic [POS_W-1:0]  ma;
  logic [LINK_W:0]   mb;

  assign share0 = (b0_pay_r.mode == SEL_SHARE);
  assign ma     = share0 ? b0_c_r : b0_pay_r.cm1;
  assign mb     = share0 ? {1'b0, b0_n_r} : {1'b0, b0_n_r} + (LINK_W+1)'(1);

  logic              b1_vld_r;
  gsp_bpay_t         b1_pay_r;
  logic [PROD_W-1:0] b1_prod_r;
  logic [LINK_W-1:0] b1_t_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b1_vld_r <= 1'b0;
    else        b1_vld_r <= b0_vld_r;
  end

  always_ff @(posedge clk) begin
    b1_pay_r  <= b0_pay_r;
    b1_prod_r <= PROD_W'(ma) * PROD_W'(mb);
    b1_t_r    <= b0_t_r;
  end

  // Form the index division
  logic                  share1;
  logic [LINK_W:0]       dd;
  logic [IDX_NUM_W-1:0]  num1;
  logic [DEN_W-1:0]      den1;

  always_comb begin
    share1 = (b1_pay_r.mode == SEL_SHARE);
    dd     = {1'b0, b1_t_r} + (LINK_W+1)'(1);
    num1   = share1 ? IDX_NUM_W'(b1_prod_r)
                    : {b1_prod_r, 1'b0} + IDX_NUM_W'(dd);
    den1   = share1 ? DEN_W'(b1_t_r) : {dd, 1'b0};
  end

  logic                       d_vld;
  logic [0:0][IDX_NUM_W-1:0]  d_quo;
  logic [BPW-1:0]             d_pay_w;
  gsp_bpay_t                  d_pay;

  gsp_div #(
    .LN (1),
    .NW (IDX_NUM_W),
    .DW (DEN_W),
    .PW (BPW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (b1_vld_r),
    .in_num  (num1),
    .in_den  (den1),
    .in_pay  (b1_pay_r),
    .out_vld (d_vld),
    .out_quo (d_quo),
    .out_pay (d_pay_w)
  );

  // Clamp the index and add it to the first point
  logic [IDX_NUM_W-1:0] pick;
  logic [POS_W-1:0]     idx;

  always_comb begin
    d_pay = gsp_bpay_t'(d_pay_w);
    pick  = ((d_pay.mode == SEL_SHARE) || (d_pay.mode == SEL_SPREAD))
            ? d_quo[0] : IDX_NUM_W'(d_pay.val);
    idx   = (pick > IDX_NUM_W'(d_pay.cm1)) ? d_pay.cm1 : pick[POS_W-1:0];
  end

  logic                b3_vld_r, b3_empty_r, b3_horiz_r;
  logic [CHOICE_W-1:0] b3_idx_r;
  logic [POS_W-1:0]    b3_pos_r, b3_edge_r, b3_cx_r, b3_cy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b3_vld_r <= 1'b0;
    else        b3_vld_r <= d_vld;
  end

  always_ff @(posedge clk) begin
    b3_empty_r <= d_pay.empty;
    b3_horiz_r <= d_pay.horiz;
    b3_idx_r   <= idx[CHOICE_W-1:0];
    b3_pos_r   <= d_pay.first + idx;
    b3_edge_r  <= d_pay.edge_pos;
    b3_cx_r    <= d_pay.cx;
    b3_cy_r    <= d_pay.cy;
  end

  // Scale from grid units to coordinates by the pitch and drive the result
  localparam int MW = POS_W + PITCH_W;
  logic [MW-1:0]    along_full, edge_full;
  logic [POS_W-1:0] along, edgev;

  assign along_full = MW'(b3_pos_r) * MW'(pitch);
  assign edge_full  = MW'(b3_edge_r) * MW'(pitch);
  assign along      = along_full[POS_W-1:0];
  assign edgev      = edge_full[POS_W-1:0];

  logic                    out_strobe_r, out_at_center_r;
  logic signed [POS_W-1:0] out_snap_x_r, out_snap_y_r;
  logic [CHOICE_W-1:0]     out_chosen_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe_r <= 1'b0;
    else        out_strobe_r <= b3_vld_r;
  end

  always_ff @(posedge clk) begin
    if (b3_empty_r) begin
      out_snap_x_r       <= b3_cx_r;
      out_snap_y_r       <= b3_cy_r;
      out_chosen_index_r <= '0;
      out_at_center_r    <= 1'b1;
    end else begin
      out_snap_x_r       <= b3_horiz_r ? along : edgev;
      out_snap_y_r       <= b3_horiz_r ? edgev : along;
      out_chosen_index_r <= b3_idx_r;
      out_at_center_r    <= 1'b0;
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_snap_x       = out_snap_x_r;
  assign out_snap_y       = out_snap_y_r;
  assign out_chosen_index = out_chosen_index_r;
  assign out_at_center    = out_at_center_r;

endmodule
`default_nettype wire

>>> rtl/core/grid_snap_port_position_core.sv
`default_nettype none
// Grid-snapped port position. One word is taken per cycle whenever busy is
// low, and its result appears on the out_ ports for exactly one cycle under
// out_strobe, in acceptance order. A word passes the 21-stage floor/ceiling
// divider of the front part, the queue, and the 35-stage index divider of
// the back part, which has register stages before and after it. The
// receiver cannot stall; the queue between the parts always drains, so busy
// stays low in operation. Write grid_pitch through cfg_wr_en/cfg_wr_data only
// while no word is in flight; a pitch of zero acts as one.
module grid_snap_port_position_core import gsp_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [PITCH_W-1:0]        cfg_wr_data,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_opcode,
  input  logic signed [COORD_W-1:0] in_left_coord,
  input  logic signed [COORD_W-1:0] in_top_coord,
  input  logic [CHOICE_W-1:0]       in_box_width,
  input  logic [CHOICE_W-1:0]       in_box_height,
  input  logic [1:0]                in_side,
  input  logic [LINK_W-1:0]         in_link_number,
  input  logic [LINK_W-1:0]         in_link_total,
  input  logic [CHOICE_W-1:0]       in_stored_choice,
  output logic                      out_strobe,
  output logic signed [POS_W-1:0]   out_snap_x,
  output logic signed [POS_W-1:0]   out_snap_y,
  output logic [CHOICE_W-1:0]       out_chosen_index,
  output logic                      out_at_center
);

  // Hold the grid pitch
  logic [PITCH_W-1:0] pitch_r, pitch_nxt, pitch_eff;

  assign pitch_nxt = cfg_wr_en ? cfg_wr_data : pitch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) pitch_r <= PITCH_W'(160);
    else        pitch_r <= pitch_nxt;
  end

  assign pitch_eff = (pitch_r == '0) ? PITCH_W'(1) : pitch_r;

  logic     q_full, f_vld, q_vld;
  gsp_mid_t f_item, q_item;

  assign busy = q_full;

  gsp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_vld           (start && !busy),
    .in_opcode        (in_opcode),
    .in_left_coord    (in_left_coord),
    .in_top_coord     (in_top_coord),
    .in_box_width     (in_box_width),
    .in_box_height    (in_box_height),
    .in_side          (in_side),
    .in_link_number   (in_link_number),
    .in_link_total    (in_link_total),
    .in_stored_choice (in_stored_choice),
    .pitch            (pitch_eff),
    .out_vld          (f_vld),
    .out_item         (f_item)
  );

  gsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_vld),
    .push_item (f_item),
    .pop       (q_vld),
    .full      (q_full),
    .out_vld   (q_vld),
    .out_item  (q_item)
  );

  gsp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_vld           (q_vld),
    .in_item          (q_item),
    .pitch            (pitch_eff),
    .out_strobe       (out_strobe),
    .out_snap_x       (out_snap_x),
    .out_snap_y       (out_snap_y),
    .out_chosen_index (out_chosen_index),
    .out_at_center    (out_at_center)
  );

endmodule
`default_nettype wire

>>> rtl/core/gsp_checker.sv
`default_nettype none
module gsp_checker import gsp_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      cfg_wr_en,
  input logic [PITCH_W-1:0]        cfg_wr_data,
  input logic                      start,
  input logic                      busy,
  input logic                      in_opcode,
  input logic signed [COORD_W-1:0] in_left_coord,
  input logic signed [COORD_W-1:0] in_top_coord,
  input logic [CHOICE_W-1:0]       in_box_width,
  input logic [CHOICE_W-1:0]       in_box_height,
  input logic [1:0]                in_side,
  input logic [LINK_W-1:0]         in_link_number,
  input logic [LINK_W-1:0]         in_link_total,
  input logic [CHOICE_W-1:0]       in_stored_choice,
  input logic                      out_strobe,
  input logic signed [POS_W-1:0]   out_snap_x,
  input logic signed [POS_W-1:0]   out_snap_y,
  input logic [CHOICE_W-1:0]       out_chosen_index,
  input logic                      out_at_center
);

  // Every accepted word yields its result a fixed time later
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_strobe)
    else $error("accepted word produced no result");

  // No result without an accepted word
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##PIPE_LAT !out_strobe)
    else $error("result without accepted word");

  // Centre fallback reports index zero
  a_center_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_at_center) |-> (out_chosen_index == '0))
    else $error("centre result with nonzero index");

  // Queue drains every cycle, so no backlog builds up
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised with a non-stalling receiver");

endmodule

bind grid_snap_port_position_core gsp_checker u_gsp_checker (.*);
`default_nettype wire

>>> bench/gsp_test_pkg.sv
`default_nettype none
package gsp_test_pkg;

  // Operations carried in in_opcode
  typedef enum logic {
    OP_BY_LINK   = 1'b0,
    OP_BY_CHOICE = 1'b1
  } snap_op_e;

  // Node sides carried in in_side
  typedef enum logic [1:0] {
    SIDE_TOP    = 2'd0,
    SIDE_BOTTOM = 2'd1,
    SIDE_LEFT   = 2'd2,
    SIDE_RIGHT  = 2'd3
  } node_side_e;

  // Reset value of the register written through the cfg_ port
  localparam logic [15:0] PITCH_RESET = 16'd160;

endpackage
`default_nettype wire

>>> bench/grid_snap_port_position_checker.sv
`default_nettype none
module grid_snap_port_position_checker import gsp_pkg::*; import gsp_test_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [PITCH_W-1:0]        cfg_wr_data,
  input  logic                      start,
  input  logic                      busy,
  input  logic                      in_opcode,
  input  logic signed [COORD_W-1:0] in_left_coord,
  input  logic signed [COORD_W-1:0] in_top_coord,
  input  logic [CHOICE_W-1:0]       in_box_width,
  input  logic [CHOICE_W-1:0]       in_box_height,
  input  logic [1:0]                in_side,
  input  logic [LINK_W-1:0]         in_link_number,
  input  logic [LINK_W-1:0]         in_link_total,
  input  logic [CHOICE_W-1:0]       in_stored_choice,
  input  logic                      out_strobe,
  input  logic signed [POS_W-1:0]   out_snap_x,
  input  logic signed [POS_W-1:0]   out_snap_y,
  input  logic [CHOICE_W-1:0]       out_chosen_index,
  input  logic                      out_at_center,
  output int                        fail_count,
  output int                        words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [POS_W-1:0]    snap_x;
    logic [POS_W-1:0]    snap_y;
    logic [CHOICE_W-1:0] chosen_index;
    logic                at_center;
  } port_pos_t;

  logic [PITCH_W-1:0] pitch_q;
  port_pos_t          expected_pos_q[$];

  function automatic longint floor_q(longint a, longint g);
    longint q;
    q = a / g;
    if ((a % g) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic longint ceil_q(longint a, longint g);
    return -floor_q(-a, g);
  endfunction

  // Work out the snapped port position for one accepted word
  function automatic port_pos_t snap_port(
    logic op, logic signed [COORD_W-1:0] lx, logic signed [COORD_W-1:0] ty,
    logic [CHOICE_W-1:0] bw, logic [CHOICE_W-1:0] bh, logic [1:0] sd,
    logic [LINK_W-1:0] ln, logic [LINK_W-1:0] lt, logic [CHOICE_W-1:0] sc,
    logic [PITCH_W-1:0] pitch);
    port_pos_t r;
    longint g, x, y, w, h, lo, hi, first, cnt, along, edge_v;
    longint unsigned c, idx, n, t, d;
    logic horiz;
    g = (pitch == 0) ? 1 : longint'(pitch);
    x = longint'(lx);
    y = longint'(ty);
    w = longint'({1'b0, bw});
    h = longint'({1'b0, bh});
    n = ln;
    t = lt;
    horiz = (sd == SIDE_TOP) || (sd == SIDE_BOTTOM);
    lo = horiz ? x : y;
    hi = horiz ? x + w : y + h;
    first = ceil_q(lo, g);
    cnt = floor_q(hi, g) - first + 1;
    // no grid point on the side: fall back to the centre
    if (cnt <= 0) begin
      r.snap_x = POS_W'(x + w / 2);
      r.snap_y = POS_W'(y + h / 2);
      r.chosen_index = '0;
      r.at_center = 1'b1;
      return r;
    end
    c = cnt;
    if (op == OP_BY_CHOICE) begin
      idx = (sc < c - 1) ? sc : c - 1;
    end else if (n < t) begin
      if (t >= c) begin
        idx = (n * c) / t;
        if (idx > c - 1) idx = c - 1;
      end else begin
        d = t + 1;
        idx = ((c - 1) * (n + 1) * 2 + d) / (2 * d);
      end
    end else begin
      idx = (n < c - 1) ? n : c - 1;
    end
    along = (first + longint'(idx)) * g;
    case (sd)
      SIDE_TOP:    edge_v = floor_q(y, g) * g;
      SIDE_BOTTOM: edge_v = ceil_q(y + h, g) * g;
      SIDE_LEFT:   edge_v = floor_q(x, g) * g;
      default:     edge_v = ceil_q(x + w, g) * g;
    endcase
    r.snap_x = POS_W'(horiz ? along : edge_v);
    r.snap_y = POS_W'(horiz ? edge_v : along);
    r.chosen_index = CHOICE_W'(idx);
    r.at_center = 1'b0;
    return r;
  endfunction

  assign words_pending = expected_pos_q.size();

  // Track the pitch, queue predictions for accepted words, compare results
  always @(posedge clk) begin
    port_pos_t got, want;
    if (!rst_n) begin
      pitch_q <= PITCH_RESET;
      expected_pos_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_wr_en) pitch_q <= cfg_wr_data;
      if (start && !busy)
        expected_pos_q.insert(expected_pos_q.size(),
          snap_port(in_opcode, in_left_coord, in_top_coord,
          in_box_width, in_box_height, in_side, in_link_number, in_link_total,
          in_stored_choice, pitch_q));
      if (out_strobe) begin
        got = '{out_snap_x, out_snap_y, out_chosen_index, out_at_center};
        if (expected_pos_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result word x=%0d y=%0d idx=%0d ctr=%0b",
                     $realtime, out_snap_x, out_snap_y, out_chosen_index,
                     out_at_center);
        end else begin
          want = expected_pos_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp x=%0d y=%0d idx=%0d ctr=%0b",
                       $realtime, $signed(want.snap_x), $signed(want.snap_y),
                       want.chosen_index, want.at_center,
                       " got x=%0d y=%0d idx=%0d ctr=%0b",
                       out_snap_x, out_snap_y, out_chosen_index, out_at_center);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> bench/grid_snap_port_position_core_test.sv
`default_nettype none
module grid_snap_port_position_core_test import gsp_pkg::*; import gsp_test_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_WORDS = 1330;
  localparam int CALM_WORDS = 150;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_wr_en = 1'b0;
  logic [PITCH_W-1:0]        cfg_wr_data = '0;
  logic                      start = 1'b0;
  logic                      busy;
  logic                      in_opcode = 1'b0;
  logic signed [COORD_W-1:0] in_left_coord = '0;
  logic signed [COORD_W-1:0] in_top_coord = '0;
  logic [CHOICE_W-1:0]       in_box_width = '0;
  logic [CHOICE_W-1:0]       in_box_height = '0;
  logic [1:0]                in_side = '0;
  logic [LINK_W-1:0]         in_link_number = '0;
  logic [LINK_W-1:0]         in_link_total = '0;
  logic [CHOICE_W-1:0]       in_stored_choice = '0;
  logic                      out_strobe;
  logic signed [POS_W-1:0]   out_snap_x;
  logic signed [POS_W-1:0]   out_snap_y;
  logic [CHOICE_W-1:0]       out_chosen_index;
  logic                      out_at_center;
  int                        fail_count;
  int                        words_pending;
  int                        cycle_count = 0;
  logic [PITCH_W-1:0]        cur_pitch = PITCH_RESET;

  always #6 clk = ~clk;

  grid_snap_port_position_core dut (.*);

  grid_snap_port_position_checker checker_i (.*);

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one word and hold it until accepted
  task automatic send_word(logic op, logic signed [COORD_W-1:0] lx,
    logic signed [COORD_W-1:0] ty, logic [CHOICE_W-1:0] bw, logic [CHOICE_W-1:0] bh,
    logic [1:0] sd, logic [LINK_W-1:0] ln, logic [LINK_W-1:0] lt,
    logic [CHOICE_W-1:0] sc);
    in_opcode <= op;
    in_left_coord <= lx;
    in_top_coord <= ty;
    in_box_width <= bw;
    in_box_height <= bh;
    in_side <= sd;
    in_link_number <= ln;
    in_link_total <= lt;
    in_stored_choice <= sc;
    start <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(13, 1)) @(posedge clk);
  endtask

  // Drain, let the pipe empty, then write the pitch
  task automatic set_pitch(logic [PITCH_W-1:0] p);
    start <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= p;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_pitch = p;
  endtask

  // Span length scaled to the pitch: under one pitch, one to four pitches, up to forty, or anything
  function automatic logic [CHOICE_W-1:0] pick_span();
    int unsigned g;
    g = (cur_pitch == 0) ? 1 : cur_pitch;
    case ($urandom_range(3, 0))
      0: return CHOICE_W'($urandom_range(g - 1, 0));
      1: return CHOICE_W'($urandom_range(g * 4, g));
      2: return CHOICE_W'($urandom_range(g * 40 < 262143 ? g * 40 : 262143, 0));
      default: return CHOICE_W'($urandom);
    endcase
  endfunction

  task automatic random_word();
    logic [LINK_W-1:0] lt, ln;
    lt = ($urandom_range(3, 0) == 0) ? LINK_W'($urandom) : LINK_W'($urandom_range(40, 0));
    case ($urandom_range(4, 0))
      0: ln = LINK_W'($urandom);
      1: ln = lt;
      default: ln = (lt == 0) ? '0 : LINK_W'($urandom_range(lt - 1, 0));
    endcase
    send_word(1'($urandom_range(1, 0)), COORD_W'($urandom), COORD_W'($urandom),
              pick_span(), pick_span(), 2'($urandom_range(3, 0)), ln, lt,
              ($urandom_range(1, 0) ? CHOICE_W'($urandom) : CHOICE_W'($urandom_range(20, 0))));
  endtask

  initial begin
    logic [PITCH_W-1:0] pitches[6];
    int phase_words;
    pitches = '{16'd160, 16'd1, 16'hFFFF, 16'd0, 16'd7, 16'd16};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_pitch(PITCH_RESET);

    // Directed corners: extreme fields, every side and operation
    send_word(OP_BY_LINK, 20'sh80000, 20'sh80000, 18'h3FFFF, 18'h3FFFF, SIDE_TOP,
              12'd0, 12'd0, 18'd0);
    send_word(OP_BY_LINK, 20'sh7FFFF, 20'sh7FFFF, 18'h3FFFF, 18'h3FFFF, SIDE_BOTTOM,
              12'hFFF, 12'hFFF, 18'h3FFFF);
    send_word(OP_BY_CHOICE, 20'sh80000, 20'sh7FFFF, 18'h3FFFF, 18'd0, SIDE_LEFT,
              12'd0, 12'd5, 18'h3FFFF);
    send_word(OP_BY_CHOICE, 20'sh7FFFF, 20'sh80000, 18'd0, 18'h3FFFF, SIDE_RIGHT,
              12'hFFF, 12'd0, 18'd0);
    // first side too short for a grid point (centre with odd size), second short side holds one point
    send_word(OP_BY_LINK, 20'sd1, 20'sd1, 18'd157, 18'd157, SIDE_TOP, 12'd0, 12'd1, 18'd0);
    send_word(OP_BY_LINK, -20'sd159, -20'sd3, 18'd157, 18'd3, SIDE_RIGHT, 12'd0, 12'd1, 18'd0);
    // exactly one point, on a negative boundary
    send_word(OP_BY_LINK, -20'sd160, 20'sd0, 18'd0, 18'd0, SIDE_BOTTOM, 12'd3, 12'd4, 18'd9);
    // more links than points: shared points
    send_word(OP_BY_LINK, 20'sd0, 20'sd0, 18'd480, 18'd480, SIDE_TOP, 12'd7, 12'd8, 18'd0);
    // fewer links than points: even spread
    send_word(OP_BY_LINK, 20'sd5, -20'sd7, 18'd3200, 18'd3200, SIDE_LEFT, 12'd1, 12'd3, 18'd0);
    send_word(OP_BY_LINK, 20'sd5, -20'sd7, 18'd3200, 18'd3200, SIDE_RIGHT, 12'd2, 12'd3, 18'd0);
    // link number past the total, total zero
    send_word(OP_BY_LINK, 20'sd0, 20'sd0, 18'd3200, 18'd3200, SIDE_BOTTOM, 12'd40, 12'd2, 18'd0);
    send_word(OP_BY_LINK, 20'sd0, 20'sd0, 18'd3200, 18'd3200, SIDE_TOP, 12'd3, 12'd0, 18'd0);
    // stored choice within and past the points
    send_word(OP_BY_CHOICE, 20'sd0, 20'sd0, 18'd3200, 18'd3200, SIDE_LEFT, 12'd0, 12'd0, 18'd4);
    send_word(OP_BY_CHOICE, 20'sd0, 20'sd0, 18'd3200, 18'd3200, SIDE_TOP, 12'd0, 12'd0, 18'd99);

    // Random phases, one per pitch; no gaps near the end
    phase_words = RANDOM_WORDS / 6;
    for (int p = 0; p < 6; p++) begin
      set_pitch(pitches[p] == 16'd7 ? PITCH_W'($urandom_range(65535, 1)) : pitches[p]);
      for (int i = 0; i < phase_words; i++) begin
        random_word();
        if (!(p == 5 && i >= phase_words - CALM_WORDS) && $urandom_range(7, 0) == 0)
          idle_burst();
      end
    end
    start <= 1'b0;

    // Drain and let stray results show up
    while (words_pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

>>> filelist.f
rtl/core/gsp_pkg.sv
rtl/core/gsp_div.sv
rtl/core/gsp_front.sv
rtl/core/gsp_queue.sv
rtl/core/gsp_back.sv
rtl/core/grid_snap_port_position_core.sv
rtl/core/gsp_checker.sv
bench/gsp_test_pkg.sv
bench/grid_snap_port_position_checker.sv
bench/grid_snap_port_position_core_test.sv
